FILE: rtl/bcfd_pkg.sv
// Package with shared types and constants for the BMS CAN frame decoder.
`default_nettype none
package bcfd_pkg;

    localparam int NUM_CELLS = 19;
    localparam int NUM_TEMPS = 4;
    localparam int CELL_IDX_W = $clog2(NUM_CELLS);
    localparam int SPAN_W = $clog2(NUM_CELLS + 1);
    localparam int TCNT_W = $clog2(NUM_TEMPS + 1);

    localparam logic [7:0] FUNC_CELL_FIRST = 8'hC8;
    localparam logic [7:0] FUNC_CELL_LAST = 8'hCC;
    localparam logic [7:0] FUNC_TEMP = 8'hB4;
    localparam logic [7:0] FUNC_SUMMARY = 8'hFE;
    localparam logic [7:0] SUB_SUMMARY = 8'h28;
    localparam logic [7:0] TEMP_ABSENT_HI = 8'hFF;
    localparam logic [7:0] TEMP_ABSENT_LO = 8'h00;
    localparam logic [7:0] TEMP_OFFSET = 8'd40;

    localparam logic [1:0] KIND_OTHER = 2'd0;
    localparam logic [1:0] KIND_CELL = 2'd1;
    localparam logic [1:0] KIND_TEMP = 2'd2;
    localparam logic [1:0] KIND_SUMMARY = 2'd3;

    localparam logic [0:0] REG_EMPTY = 1'd0;
    localparam logic [0:0] REG_FULL = 1'd1;

    // Classified frame handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  group;
        logic [63:0] data;
    } cmd_t;

    // Result item.
    typedef struct packed {
        logic signed [8:0] temp_d;
        logic signed [8:0] temp_c;
        logic signed [8:0] temp_b;
        logic signed [8:0] temp_a;
        logic [2:0]         temps_known;
        logic signed [10:0] charge_tenths;
        logic [20:0]        pack_mv;
        logic [15:0]        mean_cell_mv;
        logic [15:0]        lowest_cell_mv;
        logic [15:0]        highest_cell_mv;
        logic [4:0]         cells_known;
        logic [31:0]        frames_seen;
    } result_t;

endpackage
`default_nettype wire

FILE: rtl/bcfd_front.sv
// Front end: accepts frames, classifies them and pushes commands into a queue.
`default_nettype none
module bcfd_front
    import bcfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [28:0] frame_id,
    input  wire logic [3:0]  frame_length,
    input  wire logic [63:0] frame_data,
    output logic             cmd_valid,
    input  wire logic        cmd_ready,
    output cmd_t             cmd
);

    localparam int DEPTH = 2;

    cmd_t        q_reg [DEPTH];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [7:0]  func;
    logic [7:0]  sub;
    cmd_t        new_cmd;
    logic        push, pop;

    assign func = frame_id[23:16];
    assign sub  = frame_id[15:8];

    always_comb
    begin
        new_cmd.data  = frame_data;
        new_cmd.group = 3'(func - FUNC_CELL_FIRST);
        if (func >= FUNC_CELL_FIRST && func <= FUNC_CELL_LAST && frame_length == 4'd8)
            new_cmd.kind = KIND_CELL;
        else if (func == FUNC_TEMP && frame_length >= 4'd4)
            new_cmd.kind = KIND_TEMP;
        else if (func == FUNC_SUMMARY && sub == SUB_SUMMARY && frame_length >= 4'd4)
            new_cmd.kind = KIND_SUMMARY;
        else
            new_cmd.kind = KIND_OTHER;
    end

    assign in_ready  = (cnt_reg != 2'(DEPTH));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= new_cmd;
    end

endmodule
`default_nettype wire

FILE: rtl/bcfd_divider.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module bcfd_divider
    import bcfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] dividend,
    input  wire logic [17:0] divisor,
    output logic             done,
    output logic [31:0]      quotient
);

    logic [31:0] quo_reg, quo_next;
    logic [17:0] rem_reg, rem_next;
    logic [17:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [18:0] trial;

    assign trial    = {rem_reg, quo_reg[31]};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 18'd0;
            div_next  = divisor;
            cnt_next  = 6'd32;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 18'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[17:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

endmodule
`default_nettype wire

FILE: rtl/bcfd_back.sv
// Back end: applies commands to the cell and temperature state, holds the result.
`default_nettype none
module bcfd_back
    import bcfd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd,
    input  wire logic [15:0] empty_mv,
    input  wire logic [15:0] full_mv,
    output logic             res_valid,
    input  wire logic        res_ready,
    output result_t          res
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WRITE  = 4'd1;
    localparam logic [3:0] ST_SCAN   = 4'd2;
    localparam logic [3:0] ST_MEAN   = 4'd3;
    localparam logic [3:0] ST_MWAIT  = 4'd4;
    localparam logic [3:0] ST_CPREP  = 4'd5;
    localparam logic [3:0] ST_CMUL   = 4'd6;
    localparam logic [3:0] ST_CDIV   = 4'd7;
    localparam logic [3:0] ST_CWAIT  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    logic [3:0]  state_reg, state_next;
    logic [15:0] cell_reg [NUM_CELLS];
    logic [7:0]  temp_reg [NUM_TEMPS];
    logic [SPAN_W-1:0] span_reg;
    logic [TCNT_W-1:0] tspan_reg;
    logic [15:0] max_reg, min_reg, mean_reg;
    logic [20:0] sum_reg;
    logic signed [10:0] charge_reg;
    logic [31:0] tally_reg;
    logic [SPAN_W-1:0] idx_reg;
    logic [20:0] acc_reg;
    logic [15:0] hi_reg, lo_reg;
    logic [63:0] data_reg;
    logic [2:0]  group_reg;
    logic [26:0] num_reg;
    logic [17:0] den_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    logic        div_start;
    logic [31:0] div_dividend;
    logic [17:0] div_divisor;
    logic        div_done;
    logic [31:0] div_q;
    logic [16:0] d_diff;
    logic [16:0] n_diff;
    logic [15:0] cur;
    logic [CELL_IDX_W-1:0] cur_idx;

    bcfd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cmd_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign cur_idx   = idx_reg[CELL_IDX_W-1:0];
    assign cur       = cell_reg[cur_idx];
    assign d_diff    = {1'b0, full_mv} - {1'b0, empty_mv};
    assign n_diff    = {1'b0, mean_reg} - {1'b0, empty_mv};

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = 32'd0;
        div_divisor  = 18'd1;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid && cmd_ready)
                    state_next = (cmd.kind == KIND_CELL) ? ST_WRITE : ST_OUT;
            ST_WRITE: state_next = ST_SCAN;
            ST_SCAN:
                if (idx_reg == span_reg || idx_reg == SPAN_W'(NUM_CELLS))
                    state_next = ST_MEAN;
            ST_MEAN:
                if (span_reg == '0)
                    state_next = ST_CPREP;
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = 32'(acc_reg);
                    div_divisor  = 18'(span_reg);
                    state_next   = ST_MWAIT;
                end
            ST_MWAIT: if (div_done) state_next = ST_CPREP;
            ST_CPREP:
                if (full_mv <= empty_mv || mean_reg <= empty_mv)
                    state_next = ST_OUT;
                else
                    state_next = ST_CMUL;
            ST_CMUL: state_next = ST_CDIV;
            ST_CDIV:
            begin
                div_start    = 1'b1;
                div_dividend = 32'(num_reg);
                div_divisor  = den_reg;
                state_next   = ST_CWAIT;
            end
            ST_CWAIT: if (div_done) state_next = ST_OUT;
            ST_OUT: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            span_reg      <= '0;
            tspan_reg     <= '0;
            max_reg       <= 16'd0;
            min_reg       <= 16'hFFFF;
            mean_reg      <= 16'd0;
            sum_reg       <= 21'd0;
            charge_reg    <= -11'sd1;
            tally_reg     <= 32'd0;
            idx_reg       <= '0;
            for (int i = 0; i < NUM_CELLS; i++)
                cell_reg[i] <= 16'd0;
            for (int i = 0; i < NUM_TEMPS; i++)
                temp_reg[i] <= TEMP_OFFSET;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid && res_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (cmd_valid && cmd_ready)
                    begin
                        tally_reg <= tally_reg + 32'd1;
                        data_reg  <= cmd.data;
                        group_reg <= cmd.group;
                        if (cmd.kind == KIND_TEMP)
                        begin
                            logic [TCNT_W-1:0] n;
                            n = '0;
                            for (int i = 0; i < 4; i++)
                            begin
                                if (cmd.data[8*i +: 8] != TEMP_ABSENT_HI &&
                                    cmd.data[8*i +: 8] != TEMP_ABSENT_LO &&
                                    n < TCNT_W'(NUM_TEMPS))
                                begin
                                    temp_reg[n[$clog2(NUM_TEMPS)-1:0]] <= cmd.data[8*i +: 8];
                                    n = n + 1'b1;
                                end
                            end
                            tspan_reg <= n;
                        end
                        else if (cmd.kind == KIND_SUMMARY)
                        begin
                            max_reg <= {cmd.data[15:8], cmd.data[7:0]};
                            min_reg <= {cmd.data[31:24], cmd.data[23:16]};
                        end
                    end
                ST_WRITE:
                begin
                    logic [SPAN_W-1:0] span_new;
                    span_new = span_reg;
                    for (int i = 0; i < 4; i++)
                    begin
                        logic [5:0]  pos;
                        logic [15:0] mv;
                        pos = {group_reg, 2'b00} + 6'(i);
                        mv  = {data_reg[16*i +: 8], data_reg[16*i+8 +: 8]};
                        if (mv != 16'd0 && pos < 6'(NUM_CELLS))
                        begin
                            cell_reg[pos[CELL_IDX_W-1:0]] <= mv;
                            if (pos + 6'd1 > 6'(span_new))
                                span_new = SPAN_W'(pos + 6'd1);
                        end
                    end
                    span_reg <= span_new;
                    idx_reg <= '0;
                    acc_reg <= 21'd0;
                    hi_reg  <= 16'd0;
                    lo_reg  <= 16'hFFFF;
                end
                ST_SCAN:
                    if (!(idx_reg == span_reg || idx_reg == SPAN_W'(NUM_CELLS)))
                    begin
                        if (cur != 16'd0)
                        begin
                            acc_reg <= acc_reg + 21'(cur);
                            if (cur > hi_reg) hi_reg <= cur;
                            if (cur < lo_reg) lo_reg <= cur;
                        end
                        idx_reg <= idx_reg + 1'b1;
                    end
                ST_MEAN:
                begin
                    max_reg <= hi_reg;
                    min_reg <= lo_reg;
                    sum_reg <= acc_reg;
                    if (span_reg == '0)
                        mean_reg <= 16'd0;
                end
                ST_MWAIT: if (div_done) mean_reg <= div_q[15:0];
                ST_CPREP:
                begin
                    if (full_mv <= empty_mv)
                        charge_reg <= (mean_reg > empty_mv) ? 11'sd1000 : 11'sd0;
                    else if (mean_reg <= empty_mv)
                        charge_reg <= 11'sd0;
                    den_reg <= {d_diff, 1'b0};
                end
                ST_CMUL:
                    num_reg <= 27'(n_diff) * 27'd2000 + 27'(d_diff);
                ST_CWAIT:
                    if (div_done)
                        charge_reg <= (div_q > 32'd1000) ? 11'sd1000 : $signed(div_q[10:0]);
                ST_OUT:
                    out_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_reg.frames_seen     = tally_reg;
        out_reg.cells_known     = 5'(span_reg);
        out_reg.highest_cell_mv = max_reg;
        out_reg.lowest_cell_mv  = min_reg;
        out_reg.mean_cell_mv    = mean_reg;
        out_reg.pack_mv         = sum_reg;
        out_reg.charge_tenths   = charge_reg;
        out_reg.temps_known     = 3'(tspan_reg);
        out_reg.temp_a          = $signed({1'b0, temp_reg[0]}) - 9'sd40;
        out_reg.temp_b          = $signed({1'b0, temp_reg[1]}) - 9'sd40;
        out_reg.temp_c          = $signed({1'b0, temp_reg[2]}) - 9'sd40;
        out_reg.temp_d          = $signed({1'b0, temp_reg[3]}) - 9'sd40;
    end

endmodule
`default_nettype wire

FILE: rtl/bms_can_frame_decoder_unit.sv
// Top level of the BMS CAN frame decoder with stream ports and APB registers.
// Input to result: a non-cell frame passes the two-entry front-end queue and the back end's
// idle and output states; a cell frame also passes the write state, one scan step per known
// cell plus one and up to two waits on one shared radix-2 divider. The back end takes the
// next frame after its result is taken; the queue keeps accepting frames until it is full.
// Reset (rst_n low, asynchronous) clears all cell, temperature and summary state.
`default_nettype none
module bms_can_frame_decoder_unit
    import bcfd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // Slave stream. tdata from bit 0: frame_id[28:0], frame_length[3:0],
    // byte0..byte7 (8 bits each), then 7 zero bits.
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [103:0] s_tdata,
    // Master stream. tdata from bit 0: frames_seen[31:0], cells_known[4:0],
    // highest_cell_mv, lowest_cell_mv, mean_cell_mv (16 each), pack_mv[20:0],
    // charge_tenths[10:0], temps_known[2:0], temp_a..temp_d (9 each), 4 zero bits.
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,
    // Configuration port.
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] empty_reg;
    logic [15:0] full_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;
    result_t     res;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register file: empty voltage at offset 0, full voltage at offset 4.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= 16'd2500;
            full_reg  <= 16'd3387;
        end
        else if (wr_en && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2:2])
                REG_EMPTY: empty_reg <= pwdata[15:0];
                REG_FULL:  full_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2:2])
            REG_EMPTY: prdata = {16'd0, empty_reg};
            REG_FULL:  prdata = {16'd0, full_reg};
            default:   prdata = 32'd0;
        endcase
    end

    // The front end classifies each frame transaction and queues it.
    bcfd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .frame_id     (s_tdata[28:0]),
        .frame_length (s_tdata[32:29]),
        .frame_data   (s_tdata[96:33]),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    // The back end updates state and holds one result until it is taken.
    bcfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty_mv  (empty_reg),
        .full_mv   (full_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {4'd0, res};

    // The result register must not be overwritten while waiting.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A taken result is not shown again with the same frame count.
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready |=> !m_tvalid || m_tdata[31:0] != $past(m_tdata[31:0]))
        else $error("result repeated");

    // Charge never exceeds 1000 tenths while a result is shown.
    a_charge: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(res.charge_tenths) <= 11'sd1000)
        else $error("charge out of range");

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the BMS CAN frame decoder with stream and APB ports.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
    import bcfd_pkg::*;
;

    // One CAN frame as the stream carries it. byte 0 sits just above the length.
    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [3:0]      len;
        logic [28:0]     id;
    } can_frame_t;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 120;
    localparam logic [2:0] ADDR_EMPTY = 3'(4 * REG_EMPTY);
    localparam logic [2:0] ADDR_FULL = 3'(4 * REG_FULL);

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // tdata from bit 0: frame_id, frame_length, byte0..byte7.
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // tdata from bit 0: frames_seen, cells_known, highest, lowest, mean, pack_mv,
    // charge_tenths, temps_known, temp_a..temp_d.
    logic [159:0] m_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    bms_can_frame_decoder_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Frames waiting to be offered, and status words the decoder still owes us.
    can_frame_t pending_frames[$];
    result_t    expected_status[$];

    int  mismatches = 0;
    bit  no_idle = 1'b0;     // when set, neither side inserts gaps
    int  hold_requests = 0;  // bumped by the sequencer to ask for a long receiver stall

    // Shadow of the decoder state, kept by the predictor.
    logic [15:0] cell_mv[NUM_CELLS];
    logic [4:0]  known_cells;
    logic [7:0]  temp_raw[4];
    logic [2:0]  valid_temps;
    logic [15:0] high_mv, low_mv, avg_mv;
    logic [20:0] sum_mv;
    logic signed [10:0] soc_tenths;
    logic [31:0] frames_total;
    logic [15:0] cfg_empty_mv, cfg_full_mv;

    task automatic clear_shadow();
        for (int i = 0; i < NUM_CELLS; i++)
            cell_mv[i] = '0;
        for (int i = 0; i < 4; i++)
            temp_raw[i] = TEMP_OFFSET;
        known_cells = '0;
        valid_temps = '0;
        high_mv = '0;
        low_mv = 16'hFFFF;
        avg_mv = '0;
        sum_mv = '0;
        soc_tenths = -11'sd1;
        frames_total = '0;
        cfg_empty_mv = 16'd2500;
        cfg_full_mv = 16'd3387;
    endtask

    // State of charge in tenths of a percent, rounded half up and clamped.
    function automatic logic signed [10:0] soc_from_mean(logic [15:0] mean_mv);
        longint span, num, q;
        span = longint'(cfg_full_mv) - longint'(cfg_empty_mv);
        num = (longint'(mean_mv) - longint'(cfg_empty_mv)) * 1000;
        if (span <= 0)
            return (mean_mv > cfg_empty_mv) ? 11'sd1000 : 11'sd0;
        if (num <= 0)
            return 11'sd0;
        q = (2 * num + span) / (2 * span);
        if (q > 1000)
            q = 1000;
        return 11'(q);
    endfunction

    // Applies one frame to the shadow state and returns the status it should produce.
    function automatic result_t decode_frame(can_frame_t f);
        result_t r;
        logic [7:0] func, sub;
        logic [15:0] mv;
        int base, pos, hi, lo, total;
        func = f.id[23:16];
        sub = f.id[15:8];
        frames_total = frames_total + 32'd1;
        if (func >= FUNC_CELL_FIRST && func <= FUNC_CELL_LAST && f.len == 4'd8)
        begin
            base = 4 * (func - FUNC_CELL_FIRST);
            for (int i = 0; i < 4; i++)
            begin
                mv = {f.bytes[2 * i], f.bytes[2 * i + 1]};
                pos = base + i;
                if (mv != 0 && pos < NUM_CELLS)
                begin
                    cell_mv[pos] = mv;
                    if (pos + 1 > known_cells)
                        known_cells = 5'(pos + 1);
                end
            end
            hi = 0;
            lo = 16'hFFFF;
            total = 0;
            for (int i = 0; i < known_cells; i++)
            begin
                if (cell_mv[i] != 0)
                begin
                    total += cell_mv[i];
                    if (cell_mv[i] > hi)
                        hi = cell_mv[i];
                    if (cell_mv[i] < lo)
                        lo = cell_mv[i];
                end
            end
            high_mv = 16'(hi);
            low_mv = 16'(lo);
            sum_mv = 21'(total);
            avg_mv = (known_cells != 0) ? 16'(total / known_cells) : 16'd0;
            soc_tenths = soc_from_mean(avg_mv);
        end
        else if (func == FUNC_TEMP && f.len >= 4)
        begin
            valid_temps = '0;
            for (int i = 0; i < 4; i++)
            begin
                if (f.bytes[i] != TEMP_ABSENT_HI && f.bytes[i] != TEMP_ABSENT_LO
                    && valid_temps < NUM_TEMPS)
                begin
                    temp_raw[valid_temps] = f.bytes[i];
                    valid_temps = valid_temps + 3'd1;
                end
            end
        end
        else if (func == FUNC_SUMMARY && sub == SUB_SUMMARY && f.len >= 4)
        begin
            // Summary values are little-endian, unlike the cell values.
            high_mv = {f.bytes[1], f.bytes[0]};
            low_mv = {f.bytes[3], f.bytes[2]};
        end
        r.frames_seen = frames_total;
        r.cells_known = known_cells;
        r.highest_cell_mv = high_mv;
        r.lowest_cell_mv = low_mv;
        r.mean_cell_mv = avg_mv;
        r.pack_mv = sum_mv;
        r.charge_tenths = soc_tenths;
        r.temps_known = valid_temps;
        r.temp_a = {1'b0, temp_raw[0]} - 9'd40;
        r.temp_b = {1'b0, temp_raw[1]} - 9'd40;
        r.temp_c = {1'b0, temp_raw[2]} - 9'd40;
        r.temp_d = {1'b0, temp_raw[3]} - 9'd40;
        return r;
    endfunction

    // Driver: offers queued frames, with a random gap drawn for each one.
    int src_gap = 0;
    always @(posedge clk)
    begin
        can_frame_t f;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_status.push_back(decode_frame(can_frame_t'(s_tdata[96:0])));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    f = pending_frames.pop_front();
                    s_tdata <= {7'd0, f};
                    s_tvalid <= 1'b1;
                    src_gap <= no_idle ? 0 : $urandom_range(0, 8);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stall per status word, plus an occasional long hold-off.
    int sink_wait = 0;
    int long_hold = 0;
    int holds_served = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (holds_served != hold_requests)
            begin
                holds_served <= hold_requests;
                long_hold <= 600;
                m_tready <= 1'b0;
            end
            else if (long_hold > 0)
            begin
                long_hold <= long_hold - 1;
                m_tready <= (long_hold == 1);
            end
            else if (m_tvalid && m_tready)
            begin
                sink_wait <= no_idle ? 0 : $urandom_range(0, 8);
                m_tready <= no_idle;
            end
            else if (sink_wait > 0)
            begin
                sink_wait <= sink_wait - 1;
                m_tready <= (sink_wait == 1);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: every status transaction is checked against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_status.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected status transaction %h", got);
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.frames_seen !== want.frames_seen
                    || got.cells_known !== want.cells_known
                    || got.highest_cell_mv !== want.highest_cell_mv
                    || got.lowest_cell_mv !== want.lowest_cell_mv
                    || got.mean_cell_mv !== want.mean_cell_mv
                    || got.pack_mv !== want.pack_mv
                    || got.charge_tenths !== want.charge_tenths
                    || got.temps_known !== want.temps_known
                    || got.temp_a !== want.temp_a || got.temp_b !== want.temp_b
                    || got.temp_c !== want.temp_c || got.temp_d !== want.temp_d)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: frame %0d: expected n=%0d hi=%0d lo=%0d avg=%0d sum=%0d",
                            want.frames_seen, want.cells_known, want.highest_cell_mv,
                            want.lowest_cell_mv, want.mean_cell_mv, want.pack_mv);
                        $display("    soc=%0d nt=%0d t=%0d/%0d/%0d/%0d", want.charge_tenths,
                            want.temps_known, want.temp_a, want.temp_b, want.temp_c,
                            want.temp_d);
                        $display("  actual n=%0d hi=%0d lo=%0d avg=%0d sum=%0d seen=%0d",
                            got.cells_known, got.highest_cell_mv, got.lowest_cell_mv,
                            got.mean_cell_mv, got.pack_mv, got.frames_seen);
                        $display("    soc=%0d nt=%0d t=%0d/%0d/%0d/%0d", got.charge_tenths,
                            got.temps_known, got.temp_a, got.temp_b, got.temp_c, got.temp_d);
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // APB write with a setup and an access phase; the register takes the value at the access edge.
    task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= addr;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_EMPTY)
            cfg_empty_mv = value;
        else
            cfg_full_mv = value;
    endtask

    task automatic set_thresholds(input logic [15:0] empty_mv, input logic [15:0] full_mv);
        write_reg(ADDR_EMPTY, empty_mv);
        write_reg(ADDR_FULL, full_mv);
    endtask

    function automatic can_frame_t make_frame(logic [7:0] func, logic [7:0] sub,
                                              logic [3:0] len, logic [63:0] payload);
        can_frame_t f;
        f.id = {5'($urandom), func, sub, 8'($urandom)};
        f.len = len;
        // payload is written byte0 first, from the top.
        for (int i = 0; i < 8; i++)
            f.bytes[i] = payload[63 - 8 * i -: 8];
        return f;
    endfunction

    // A cell value: mostly realistic lithium levels, sometimes absent or extreme.
    function automatic logic [15:0] cell_value();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return 16'd0;
        if (pick == 1)
            return 16'($urandom);
        if (pick == 2)
            return 16'hFFFF;
        return 16'($urandom_range(2400, 4300));
    endfunction

    function automatic can_frame_t random_frame();
        int pick;
        logic [63:0] payload;
        pick = $urandom_range(0, 99);
        payload = {$urandom, $urandom};
        if (pick < 55)
        begin
            payload = {cell_value(), cell_value(), cell_value(), cell_value()};
            return make_frame(8'(FUNC_CELL_FIRST + $urandom_range(0, 4)), 8'($urandom),
                              ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd8, payload);
        end
        if (pick < 72)
        begin
            for (int i = 0; i < 4; i++)
                if ($urandom_range(0, 4) == 0)
                    payload[63 - 8 * i -: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            return make_frame(FUNC_TEMP, 8'($urandom), 4'($urandom_range(2, 15)), payload);
        end
        if (pick < 84)
            return make_frame(FUNC_SUMMARY,
                              ($urandom_range(0, 4) == 0) ? 8'($urandom) : SUB_SUMMARY,
                              4'($urandom_range(2, 15)), payload);
        // Anything else, including functions next to the decoded ones.
        return make_frame(8'($urandom), 8'($urandom), 4'($urandom), payload);
    endfunction

    task automatic drain();
        while (pending_frames.size() > 0 || s_tvalid || expected_status.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            pending_frames.push_back(random_frame());
    endtask

    initial
    begin
        clear_shadow();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed frames with the reset thresholds.
        pending_frames.push_back(make_frame(8'hFF, 8'hFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF));
        // A cell frame with nothing in it leaves the mean at zero and charge at zero.
        pending_frames.push_back(make_frame(8'hC8, 8'h00, 4'd8, 64'h0));
        pending_frames.push_back(make_frame(8'hC8, 8'h00, 4'd8, 64'h0001_0D05_0000_0FA0));
        // The last position of the top frame is past the cell array and dropped.
        pending_frames.push_back(make_frame(8'hCC, 8'h11, 4'd8, 64'hFFFF_0CE4_0DAC_FFFF));
        pending_frames.push_back(make_frame(8'hC9, 8'h00, 4'd7, 64'h0CE4_0CE4_0CE4_0CE4));
        pending_frames.push_back(make_frame(8'hCA, 8'h00, 4'd9, 64'h0CE4_0CE4_0CE4_0CE4));
        pending_frames.push_back(make_frame(8'hCB, 8'h00, 4'd8, 64'h0CE4_0000_0CE5_0CE6));
        pending_frames.push_back(make_frame(8'hC7, 8'h00, 4'd8, 64'h0CE4_0CE4_0CE4_0CE4));
        pending_frames.push_back(make_frame(8'hCD, 8'h00, 4'd8, 64'h0CE4_0CE4_0CE4_0CE4));
        // Temperature frames: absent markers are skipped, short frames only counted.
        pending_frames.push_back(make_frame(FUNC_TEMP, 8'h00, 4'd8, 64'h00FF_4101_0203_0405));
        pending_frames.push_back(make_frame(FUNC_TEMP, 8'h00, 4'd4, 64'h01FE_2850_0000_0000));
        pending_frames.push_back(make_frame(FUNC_TEMP, 8'h00, 4'd3, 64'h1111_1111_0000_0000));
        pending_frames.push_back(make_frame(FUNC_TEMP, 8'h00, 4'd4, 64'hFF00_FF00_0000_0000));
        // Summary overrides, then a wrong sub code, a short one and an all-zero override.
        pending_frames.push_back(make_frame(FUNC_SUMMARY, SUB_SUMMARY, 4'd4,
                                            64'h3412_FFFF_0000_0000));
        pending_frames.push_back(make_frame(FUNC_SUMMARY, 8'h29, 4'd8, 64'h1111_2222_0000_0000));
        pending_frames.push_back(make_frame(FUNC_SUMMARY, SUB_SUMMARY, 4'd3,
                                            64'h1111_2222_0000_0000));
        pending_frames.push_back(make_frame(FUNC_SUMMARY, SUB_SUMMARY, 4'd8,
                                            64'h0000_0000_0000_0000));
        // The next cell frame takes back the maximum and minimum.
        pending_frames.push_back(make_frame(8'hC8, 8'h00, 4'd8, 64'h0DAC_0000_0000_0000));
        pending_frames.push_back(make_frame(8'hC8, 8'h00, 4'd0, 64'h0));
        drain();

        random_phase(120);
        drain();

        // Widest span, then no gaps with a long receiver stall to fill the decoder.
        set_thresholds(16'd0, 16'hFFFF);
        no_idle = 1'b1;
        random_phase(60);
        while (pending_frames.size() > 55)
            @(posedge clk);
        hold_requests++;
        random_phase(60);
        drain();
        no_idle = 1'b0;

        // Full not above empty, at the extremes and at equality.
        set_thresholds(16'hFFFF, 16'd1);
        random_phase(100);
        drain();
        set_thresholds(16'd3300, 16'd3300);
        random_phase(100);
        drain();

        set_thresholds(16'd3000, 16'd3001);
        random_phase(80);
        drain();
        set_thresholds(16'($urandom_range(2000, 3200)), 16'($urandom_range(3300, 4300)));
        hold_requests++;
        random_phase(100);
        drain();
        set_thresholds(16'd2500, 16'd3387);
        random_phase(80);
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire
